FILE: rtl/core/wsl_pkg.sv
// Shared types and constants for the work-stealing task lane.
// Holds op codes, FSM states, config register indexes and decision structs.
// No dependencies.
package wsl_pkg;

    // Operation codes carried by an input beat
    typedef enum logic [2:0] {
        OP_PUSH_OWNER = 3'd0,
        OP_PUSH_YIELD = 3'd1,
        OP_POP_OWNER  = 3'd2,
        OP_STEAL      = 3'd3,
        OP_EXCHANGE   = 3'd4
    } t_op;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Config register indexes
    localparam logic CFG_LOCKFREE = 1'b0;
    localparam logic CFG_BURST    = 1'b1;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned BURST_W  = 8;
    localparam int unsigned STREAK_W = 8;
    localparam int unsigned DEPTH_W  = 10;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX       = 10'd1023;
    localparam logic               LOCKFREE_RST    = 1'b1;
    localparam logic [BURST_W-1:0] BURST_RST       = 8'd8;

    // Queue status seen by the decision logic
    typedef struct packed {
        logic lf;
        logic dq_empty;
        logic dq_full;
        logic fifo_empty;
        logic fifo_full;
        logic streak_hit;
        logic fifo_hit;
        logic dq_hit;
    } t_cond;

    // Actions and result flags chosen for one operation
    typedef struct packed {
        logic ok;
        logic next_valid;
        logic sel_fifo;
        logic spilled;
        logic push_failed;
        logic streak_cleared;
        logic dq_push;
        logic dq_pop;
        logic dq_steal;
        logic fifo_push;
        logic fifo_pop;
        logic depth_inc;
        logic depth_dec;
    } t_ctrl;

endpackage

FILE: rtl/core/wsl_ctrl.sv
// Operation decision logic for the work-stealing task lane.
// Maps an op and the queue status to pointer actions and result flags.
// Depends on wsl_pkg.
module wsl_ctrl (
    input  wsl_pkg::t_op   i_op,
    input  wsl_pkg::t_cond i_cond,
    output wsl_pkg::t_ctrl o_ctrl
);
    import wsl_pkg::*;

    logic prefer;

    always_comb begin
        o_ctrl = '0;
        // exchange prefers the deque bottom once the streak reaches the burst
        prefer = i_cond.streak_hit && !i_cond.dq_empty;
        unique case (i_op)
            OP_PUSH_OWNER: begin
                if (i_cond.lf) begin
                    if (!i_cond.dq_full) begin
                        o_ctrl.dq_push   = 1'b1;
                        o_ctrl.ok        = 1'b1;
                        o_ctrl.depth_inc = 1'b1;
                    end else begin
                        o_ctrl.spilled = 1'b1;
                    end
                end else if (!i_cond.fifo_full) begin
                    o_ctrl.fifo_push = 1'b1;
                    o_ctrl.ok        = 1'b1;
                    o_ctrl.depth_inc = 1'b1;
                end
            end
            OP_PUSH_YIELD: begin
                if (!i_cond.fifo_full) begin
                    o_ctrl.fifo_push = 1'b1;
                    o_ctrl.ok        = 1'b1;
                    o_ctrl.depth_inc = 1'b1;
                end
            end
            OP_POP_OWNER: begin
                if (i_cond.lf && !i_cond.dq_empty) begin
                    o_ctrl.dq_pop     = 1'b1;
                    o_ctrl.ok         = 1'b1;
                    o_ctrl.next_valid = 1'b1;
                    o_ctrl.depth_dec  = 1'b1;
                end else if (!i_cond.fifo_empty) begin
                    o_ctrl.fifo_pop   = 1'b1;
                    o_ctrl.sel_fifo   = 1'b1;
                    o_ctrl.ok         = 1'b1;
                    o_ctrl.next_valid = 1'b1;
                    o_ctrl.depth_dec  = 1'b1;
                end
            end
            OP_STEAL: begin
                if (i_cond.lf && !i_cond.dq_empty) begin
                    o_ctrl.dq_steal   = 1'b1;
                    o_ctrl.ok         = 1'b1;
                    o_ctrl.next_valid = 1'b1;
                    o_ctrl.depth_dec  = 1'b1;
                end
            end
            OP_EXCHANGE: begin
                if (i_cond.lf) begin
                    if (!prefer && !i_cond.fifo_empty) begin
                        // FIFO head; requeue the current task unless it came back
                        o_ctrl.fifo_pop   = 1'b1;
                        o_ctrl.sel_fifo   = 1'b1;
                        o_ctrl.next_valid = 1'b1;
                        o_ctrl.fifo_push  = !i_cond.fifo_hit;
                        o_ctrl.ok         = !i_cond.fifo_hit;
                    end else if (i_cond.fifo_full) begin
                        o_ctrl.push_failed = 1'b1;
                    end else if (!i_cond.dq_empty) begin
                        o_ctrl.dq_pop         = 1'b1;
                        o_ctrl.next_valid     = 1'b1;
                        o_ctrl.streak_cleared = prefer;
                        o_ctrl.fifo_push      = !i_cond.dq_hit;
                        o_ctrl.ok             = !i_cond.dq_hit;
                    end
                end
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule

FILE: rtl/core/work_stealing_task_lane.sv
// Work-stealing task lane: owner deque plus FIFO yield lane in slot memories.
// The input beat reads both slot memories; the execute state then decides,
// writes back and fills the output. No new beat is taken during execute.
// A result waiting in the output register holds off the next input beat.
// Reset (sync, active low) clears pointers, counts, depth, config to defaults;
// slot contents are not cleared.
module work_stealing_task_lane #(
    parameter int unsigned LANE_CAPACITY = 256,
    parameter int unsigned TASK_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // operation channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wsl_pkg::OP_W-1:0]      i_op,
    input  logic [TASK_BITS-1:0]          i_task_id,
    input  logic [wsl_pkg::STREAK_W-1:0]  i_handoff_streak,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_ok,
    output logic                          o_next_valid,
    output logic [TASK_BITS-1:0]          o_next_task,
    output logic                          o_spilled,
    output logic                          o_push_failed,
    output logic                          o_streak_cleared,
    output logic [wsl_pkg::DEPTH_W-1:0]   o_lane_depth_out,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [wsl_pkg::BURST_W-1:0]   i_cfg_data
);
    import wsl_pkg::*;

    localparam int unsigned PTR_W = $clog2(2 * LANE_CAPACITY);
    localparam int unsigned IDX_W = $clog2(LANE_CAPACITY);
    localparam int unsigned CNT_W = $clog2(LANE_CAPACITY + 1);
    localparam logic [PTR_W-1:0] PTR_CAP  = PTR_W'(LANE_CAPACITY);
    localparam logic [PTR_W-1:0] PTR_SPAN = PTR_W'(2 * LANE_CAPACITY);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * LANE_CAPACITY - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LANE_CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(LANE_CAPACITY);

    // pointer modulo 2*capacity to slot index
    function automatic logic [IDX_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        slot_of = (p >= PTR_CAP) ? IDX_W'(p - PTR_CAP) : IDX_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    // slot memories
    logic [TASK_BITS-1:0] dq_mem   [LANE_CAPACITY];
    logic [TASK_BITS-1:0] fifo_mem [LANE_CAPACITY];

    t_state r_state, n_state;
    logic                 r_lockfree;
    logic [BURST_W-1:0]   r_burst;
    logic [PTR_W-1:0]     r_dq_top, r_dq_bottom;
    logic [IDX_W-1:0]     r_fifo_head;
    logic [CNT_W-1:0]     r_fifo_count;
    logic [DEPTH_W-1:0]   r_depth, n_depth;

    logic [OP_W-1:0]      r_op;
    logic [TASK_BITS-1:0] r_task;
    logic [STREAK_W-1:0]  r_streak;
    logic [TASK_BITS-1:0] r_dq_rdata, r_fifo_rdata;

    logic                 r_out_valid;
    logic                 r_ok, r_next_valid, r_spilled, r_push_failed, r_streak_cleared;
    logic [TASK_BITS-1:0] r_next_task;
    logic [DEPTH_W-1:0]   r_lane_depth_out;

    logic                 in_accept;
    logic                 exec;
    logic [IDX_W-1:0]     dq_raddr;
    logic [PTR_W-1:0]     dq_count;
    logic [PTR_W-1:0]     fifo_tail_sum;
    logic [IDX_W-1:0]     fifo_tail;
    logic [IDX_W-1:0]     fifo_head_inc;
    logic [TASK_BITS-1:0] next_task;
    t_cond                cond;
    t_ctrl                ctrl;

    // sequencer: read on the input beat, execute on the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_rst_n && (!r_out_valid || i_ready);
                if (i_valid && o_ready) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign in_accept   = i_valid && o_ready;
    assign exec        = (r_state == ST_EXEC);
    assign o_cfg_ready = i_rst_n;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockfree <= LOCKFREE_RST;
            r_burst    <= BURST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOCKFREE: r_lockfree <= i_cfg_data[0];
                CFG_BURST:    r_burst    <= i_cfg_data;
                default:      r_burst    <= r_burst;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= i_op;
            r_task   <= i_task_id;
            r_streak <= i_handoff_streak;
        end
    end

    // steal reads the top, owner pop and exchange read the bottom
    assign dq_raddr = (i_op == OP_STEAL) ? slot_of(r_dq_top) : slot_of(ptr_dec(r_dq_bottom));

    // queue status
    assign dq_count      = (r_dq_bottom >= r_dq_top) ? r_dq_bottom - r_dq_top
                                                     : r_dq_bottom - r_dq_top + PTR_SPAN;
    assign fifo_tail_sum = PTR_W'(r_fifo_head) + PTR_W'(r_fifo_count);
    assign fifo_tail     = slot_of(fifo_tail_sum);
    assign fifo_head_inc = (r_fifo_head == IDX_LAST) ? '0 : r_fifo_head + IDX_W'(1);

    assign cond.lf         = r_lockfree;
    assign cond.dq_empty   = (r_dq_bottom == r_dq_top);
    assign cond.dq_full    = (dq_count >= PTR_CAP);
    assign cond.fifo_empty = (r_fifo_count == '0);
    assign cond.fifo_full  = (r_fifo_count >= CNT_CAP);
    assign cond.streak_hit = (r_streak >= r_burst);
    assign cond.fifo_hit   = (r_fifo_rdata == r_task);
    assign cond.dq_hit     = (r_dq_rdata == r_task);

    wsl_ctrl u_ctrl (
        .i_op   (t_op'(r_op)),
        .i_cond (cond),
        .o_ctrl (ctrl)
    );

    // deque slots: read on the beat, write back on execute
    always_ff @(posedge i_clk) begin
        if (exec && ctrl.dq_push) begin
            dq_mem[slot_of(r_dq_bottom)] <= r_task;
        end
        if (in_accept) begin
            r_dq_rdata <= dq_mem[dq_raddr];
        end
    end

    // FIFO slots: head read on the beat, tail written on execute
    always_ff @(posedge i_clk) begin
        if (exec && ctrl.fifo_push) begin
            fifo_mem[fifo_tail] <= r_task;
        end
        if (in_accept) begin
            r_fifo_rdata <= fifo_mem[r_fifo_head];
        end
    end

    // saturating lane depth
    always_comb begin
        n_depth = r_depth;
        if (ctrl.depth_inc && r_depth != DEPTH_MAX) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (ctrl.depth_dec && r_depth != '0) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
    end

    // pointer and counter update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq_top     <= '0;
            r_dq_bottom  <= '0;
            r_fifo_head  <= '0;
            r_fifo_count <= '0;
            r_depth      <= '0;
        end else if (exec) begin
            if (ctrl.dq_push) begin
                r_dq_bottom <= ptr_inc(r_dq_bottom);
            end else if (ctrl.dq_pop) begin
                r_dq_bottom <= ptr_dec(r_dq_bottom);
            end
            if (ctrl.dq_steal) begin
                r_dq_top <= ptr_inc(r_dq_top);
            end
            if (ctrl.fifo_pop) begin
                r_fifo_head <= fifo_head_inc;
            end
            if (ctrl.fifo_push && !ctrl.fifo_pop) begin
                r_fifo_count <= r_fifo_count + CNT_W'(1);
            end else if (ctrl.fifo_pop && !ctrl.fifo_push) begin
                r_fifo_count <= r_fifo_count - CNT_W'(1);
            end
            r_depth <= n_depth;
        end
    end

    // output register
    assign next_task = !ctrl.next_valid ? '0 :
                       ctrl.sel_fifo    ? r_fifo_rdata : r_dq_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_ok             <= ctrl.ok;
            r_next_valid     <= ctrl.next_valid;
            r_next_task      <= next_task;
            r_spilled        <= ctrl.spilled;
            r_push_failed    <= ctrl.push_failed;
            r_streak_cleared <= ctrl.streak_cleared;
            r_lane_depth_out <= n_depth;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_ok;
    assign o_next_valid     = r_next_valid;
    assign o_next_task      = r_next_task;
    assign o_spilled        = r_spilled;
    assign o_push_failed    = r_push_failed;
    assign o_streak_cleared = r_streak_cleared;
    assign o_lane_depth_out = r_lane_depth_out;

endmodule
